/* sv/lss_pkg.sv */
// Shared types, sizes and codes for the lookahead subgoal selector.
package lss_pkg;

  localparam int MAX_WAYPOINTS = 1024;
  localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
  localparam int LEN_W         = $clog2(MAX_WAYPOINTS + 1);

  localparam int COORD_W       = 24;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int DSQ_W         = 2 * DIFF_W;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int OUT_IDX_W     = 10;
  localparam int STATUS_W      = 3;
  localparam int KIND_W        = 2;

  localparam int IN_DATA_W     = 2 * COORD_W;
  localparam int OUT_PAYLOAD_W = 2 * COORD_W + OUT_IDX_W;
  localparam int OUT_DATA_W    = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd1;

  localparam logic [CFG_W-1:0] LOOKAHEAD_RESET = 16'd768;
  localparam logic [CFG_W-1:0] TOLERANCE_RESET = 16'd77;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_INTER  = 3'd1,
    ST_FINAL  = 3'd2,
    ST_NOPATH = 3'd3,
    ST_REPLAN = 3'd4,
    ST_FULL   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SCAN_LAST = 2'd0,
    SCAN_NEAR = 2'd1,
    SCAN_BAND = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic       capture;
    logic       clr_path;
    logic       append;
    logic       scan_start;
    scan_mode_t mode;
    logic       visit_update;
    logic       load_out;
    status_t    res;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              path_empty;
    logic              path_full;
    logic              scan_busy;
    logic              near_end;
    logic              off_path;
    logic              out_free;
  } dp_stat_t;

endpackage

/* sv/lookahead_subgoal_selector_top.sv */
// Top level of the lookahead subgoal selector: controller, datapath and ports.
//
// Keeps a path of up to 1024 waypoints (signed Q15.8 metres) in a RAM and
// answers one item at a time: clear, append one waypoint, or query the
// subgoal for a robot position. Every item yields exactly one result
// transfer, held in an output register so that the next item can be taken
// while it waits. The single RAM read port feeds a 4-stage squared-distance
// pipeline one waypoint per cycle, first for the last waypoint, then for a
// nearest-point pass over the whole path, then for a band search from the
// visited index, each pass draining the pipeline before the next decision.
// The path RAM has no reset; only entries below the path length are read.
module lookahead_subgoal_selector_top import lss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x [23:0], pos_y [47:24]
  input  logic [KIND_W-1:0]     s_tuser,   // kind [1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // subgoal_x [23:0], subgoal_y [47:24],
                                           // subgoal_index [57:48], zero [63:58]
  output logic [STATUS_W-1:0]   m_tuser,   // status [2:0]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* sv/lss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lss_dp.sv */
// Datapath: config registers, path store, distance pipeline, trackers, result register.
module lss_dp import lss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]   m_tuser
);

  // configuration and squared thresholds
  logic [CFG_W-1:0]      lookahead;
  logic [CFG_W-1:0]      tolerance;
  logic signed [CFG_W:0] lo;
  logic [CFG_W:0]        hi;
  logic [2*CFG_W-1:0]    la2;
  logic [2*CFG_W-1:0]    lo2;
  logic                  lo_any;
  logic [2*CFG_W+1:0]    hi2;

  // captured item and path state
  logic [KIND_W-1:0]  in_kind;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [LEN_W-1:0]   len;
  logic [IDX_W-1:0]   visited;
  logic [IDX_W-1:0]   last_idx;

  // scan
  scan_mode_t       mode;
  logic             scanning;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] start_idx;

  // distance pipeline
  logic [2*COORD_W-1:0] rdata;
  logic                 v1, v2, v3, v4;
  logic [IDX_W-1:0]     idx1, idx2, idx3, idx4;
  logic [COORD_W-1:0]   x2, y2, x3, y3, x4, y4;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]    ax, ay;
  logic [DSQ_W-1:0]     sqx, sqy, dsq;

  // trackers
  logic [DSQ_W-1:0]   dlast;
  logic [COORD_W-1:0] last_x, last_y;
  logic [IDX_W-1:0]   last_saved;
  logic [DSQ_W-1:0]   dmin;
  logic [IDX_W-1:0]   nearest;
  logic               found;
  logic [COORD_W-1:0] pick_x, pick_y;
  logic [IDX_W-1:0]   pick_idx;
  logic               in_band;

  // result register
  logic                 out_valid;
  status_t              out_status;
  logic [COORD_W-1:0]   out_x, out_y;
  logic [OUT_IDX_W-1:0] out_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LOOKAHEAD_RESET;
      tolerance <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOOKAHEAD: lookahead <= cfg_data;
        CFG_TOLERANCE: tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lo = $signed({1'b0, lookahead}) - $signed({1'b0, tolerance});
  assign hi = (CFG_W+1)'(lookahead) + (CFG_W+1)'(tolerance);

  // thresholds follow the registers; the user must move config only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    la2    <= (2*CFG_W)'(lookahead) * (2*CFG_W)'(lookahead);
    lo2    <= (2*CFG_W)'(lo[CFG_W-1:0]) * (2*CFG_W)'(lo[CFG_W-1:0]);
    lo_any <= lo[CFG_W];
    hi2    <= (2*CFG_W+2)'(hi) * (2*CFG_W+2)'(hi);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind <= s_tuser;
      in_x    <= s_tdata[COORD_W-1:0];
      in_y    <= s_tdata[2*COORD_W-1:COORD_W];
    end
  end

  assign last_idx = IDX_W'(len - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_path) begin
      len     <= '0;
      visited <= '0;
    end else begin
      if (cmd.append) begin
        len <= len + LEN_W'(1);
      end
      if (cmd.visit_update && nearest > visited) begin
        visited <= nearest;
      end
    end
  end

  lss_ram #(
    .WIDTH (2*COORD_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_path_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (len[IDX_W-1:0]),
    .wdata ({in_y, in_x}),
    .raddr (cnt),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.mode)
      SCAN_LAST: start_idx = last_idx;
      SCAN_BAND: start_idx = visited;
      default:   start_idx = '0;
    endcase
  end

  // walk the path one waypoint a cycle up to the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
    end else if (cmd.scan_start) begin
      scanning <= (start_idx <= last_idx);
    end else if (scanning && cnt == last_idx) begin
      scanning <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cnt  <= start_idx;
      mode <= cmd.mode;
    end else if (scanning && cnt != last_idx) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= scanning;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign dx = $signed({rdata[COORD_W-1], rdata[COORD_W-1:0]}) - $signed({in_x[COORD_W-1], in_x});
  assign dy = $signed({rdata[2*COORD_W-1], rdata[2*COORD_W-1:COORD_W]})
            - $signed({in_y[COORD_W-1], in_y});

  always_ff @(posedge clk) begin
    idx1 <= cnt;
    // stage 2: absolute differences
    ax   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    x2   <= rdata[COORD_W-1:0];
    y2   <= rdata[2*COORD_W-1:COORD_W];
    idx2 <= idx1;
    // stage 3: squares
    sqx  <= DSQ_W'(ax) * DSQ_W'(ax);
    sqy  <= DSQ_W'(ay) * DSQ_W'(ay);
    x3   <= x2;
    y3   <= y2;
    idx3 <= idx2;
    // stage 4: squared distance
    dsq  <= sqx + sqy;
    x4   <= x3;
    y4   <= y3;
    idx4 <= idx3;
  end

  assign in_band = (lo_any || dsq > DSQ_W'(lo2)) && dsq < DSQ_W'(hi2);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      dmin  <= '1;
      found <= 1'b0;
    end else if (v4) begin
      case (mode)
        SCAN_LAST: begin
          dlast      <= dsq;
          last_x     <= x4;
          last_y     <= y4;
          last_saved <= idx4;
        end
        SCAN_NEAR: begin
          // strict compare keeps the first minimum
          if (dsq < dmin) begin
            dmin    <= dsq;
            nearest <= idx4;
          end
        end
        SCAN_BAND: begin
          if (!found && in_band) begin
            found    <= 1'b1;
            pick_x   <= x4;
            pick_y   <= y4;
            pick_idx <= idx4;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.kind       = in_kind;
  assign stat.path_empty = (len == '0);
  assign stat.path_full  = (len >= LEN_W'(MAX_WAYPOINTS));
  assign stat.scan_busy  = scanning | v1 | v2 | v3 | v4;
  assign stat.near_end   = dlast < DSQ_W'(la2);
  assign stat.off_path   = dmin > DSQ_W'(la2);
  assign stat.out_free   = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.res;
      case (cmd.res)
        ST_FINAL: begin
          out_x   <= last_x;
          out_y   <= last_y;
          out_idx <= OUT_IDX_W'(last_saved);
        end
        ST_REPLAN: begin
          out_x   <= last_x;
          out_y   <= last_y;
          out_idx <= '0;
        end
        ST_INTER: begin
          out_x   <= found ? pick_x : last_x;
          out_y   <= found ? pick_y : last_y;
          out_idx <= OUT_IDX_W'(found ? pick_idx : last_saved);
        end
        default: begin
          out_x   <= '0;
          out_y   <= '0;
          out_idx <= '0;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = OUT_DATA_W'({out_idx, out_y, out_x});

endmodule

/* sv/lss_ctrl.sv */
// Controller: sequences clear, append and the query passes over the path.
module lss_ctrl import lss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_DECODE     = 9'b000000010,
    S_LAST_RUN   = 9'b000000100,
    S_LAST_CHK   = 9'b000001000,
    S_NEAR_RUN   = 9'b000010000,
    S_NEAR_CHK   = 9'b000100000,
    S_BAND_START = 9'b001000000,
    S_BAND_RUN   = 9'b010000000,
    S_RESULT     = 9'b100000000
  } state_t;

  state_t  state, state_next;
  status_t res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= ST_OK;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    res_next         = res;
    cmd              = '0;
    cmd.mode         = SCAN_NEAR;
    cmd.res          = res;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        res_next   = ST_OK;
        state_next = S_RESULT;
        case (stat.kind)
          KIND_CLEAR: cmd.clr_path = 1'b1;
          KIND_APPEND: begin
            if (stat.path_full) begin
              res_next = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          KIND_QUERY: begin
            if (stat.path_empty) begin
              res_next = ST_NOPATH;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.mode       = SCAN_LAST;
              state_next     = S_LAST_RUN;
            end
          end
          default: ;
        endcase
      end
      S_LAST_RUN: begin
        if (!stat.scan_busy) begin
          state_next = S_LAST_CHK;
        end
      end
      S_LAST_CHK: begin
        if (stat.near_end) begin
          res_next   = ST_FINAL;
          state_next = S_RESULT;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.mode       = SCAN_NEAR;
          state_next     = S_NEAR_RUN;
        end
      end
      S_NEAR_RUN: begin
        if (!stat.scan_busy) begin
          state_next = S_NEAR_CHK;
        end
      end
      S_NEAR_CHK: begin
        if (stat.off_path) begin
          // final goal was kept from the last-waypoint pass
          cmd.clr_path = 1'b1;
          res_next     = ST_REPLAN;
          state_next   = S_RESULT;
        end else begin
          cmd.visit_update = 1'b1;
          state_next       = S_BAND_START;
        end
      end
      S_BAND_START: begin
        cmd.scan_start = 1'b1;
        cmd.mode       = SCAN_BAND;
        state_next     = S_BAND_RUN;
      end
      S_BAND_RUN: begin
        if (!stat.scan_busy) begin
          res_next   = ST_INTER;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
